/* rtl/hilbert_index_3d_assert.svh */
// assertion macros used by the checker file
`ifndef HILBERT_INDEX_3D_ASSERT_SVH
`define HILBERT_INDEX_3D_ASSERT_SVH

// implication in the same cycle, inactive while reset is asserted
`define HI3D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, inactive while reset is asserted
`define HI3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// implication in the same cycle, also checked around reset
`define HI3D_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/hi3d_pkg.sv */
`timescale 1ns / 1ps

package hi3d_pkg;

	// largest number of axes the transform supports
	localparam int MAX_DIMS = 3;

endpackage

/* rtl/hilbert_index_3d.sv */
`timescale 1ns / 1ps

// hilbert_index_3d: Hilbert curve distance of one point (axes to transpose form)
//
// point channel: coord_x, coord_y, coord_z with point_valid / point_stall;
// a transfer happens on a rising edge with point_valid high and point_stall low
// dist channel: curve_distance with dist_valid / dist_stall, same rule
// the distance interleaves the transposed axes, top bit plane first, x highest
// in each group; with DIMS of two coord_z is ignored
//
// pipeline: BITS register stages in all, one register stage per bit plane
// from the top plane down to bit 1, then one stage for gray encoding, the
// correction mask and the interleave
// throughput: one point per cycle while dist_stall is low; each stage holds one point and moves on
// whenever the stage after it is empty or moving
//
// reset: arst_n clears every stage valid bit at once; data registers are not
// reset; the point channel is ready in the first cycle after reset
// stall: a stalled result holds on the output stage while earlier stages keep
// filling their empty slots; point_stall rises only once every stage is full

module hilbert_index_3d #(
	parameter int BITS = 10,
	parameter int DIMS = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [BITS-1:0]      coord_x,
	input  logic [BITS-1:0]      coord_y,
	input  logic [BITS-1:0]      coord_z,
	input  logic                 point_valid,
	output logic                 point_stall,
	output logic [BITS*DIMS-1:0] curve_distance,
	output logic                 dist_valid,
	input  logic                 dist_stall
);

	localparam int DW = BITS * DIMS;

	typedef logic [DIMS-1:0][BITS-1:0] axes_t;

	// all coordinates, only the first DIMS take part
	logic [BITS-1:0] coord_all [hi3d_pkg::MAX_DIMS];
	axes_t           in_ax;

	// plane stages 1 .. BITS-1, output stage BITS
	axes_t           ax_s     [1:BITS-1];
	axes_t           stg_in   [1:BITS-1];
	axes_t           stg_nxt  [1:BITS-1];
	logic [BITS:1]   valid_s;
	logic [BITS-1:0] prev_valid;
	logic [BITS+1:1] ready;
	logic [DW-1:0]   dist_s;
	logic [DW-1:0]   dist_nxt;

	assign coord_all[0] = coord_x;
	assign coord_all[1] = coord_y;
	assign coord_all[2] = coord_z;

	always_comb begin
		for (int i = 0; i < DIMS; i++) begin
			in_ax[i] = coord_all[i];
		end
	end

	// stage k may load when it is empty or its content moves on this edge
	assign ready[BITS+1] = !dist_stall;
	assign point_stall   = !ready[1];
	assign prev_valid[0] = point_valid;

	genvar k;
	generate
		for (k = 1; k <= BITS; k++) begin : g_ctl
			assign ready[k] = !valid_s[k] || ready[k+1];

			if (k < BITS) begin : g_pv
				assign prev_valid[k] = valid_s[k];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k] <= 1'b0;
				end else if (ready[k]) begin
					valid_s[k] <= prev_valid[k-1];
				end
			end
		end

		for (k = 1; k < BITS; k++) begin : g_plane
			// plane handled here: bit BITS-k, mask of the bits below it
			localparam int              P   = BITS - k;
			localparam logic [BITS-1:0] LOW = BITS'((64'd1 << P) - 64'd1);

			if (k == 1) begin : g_src_in
				assign stg_in[k] = in_ax;
			end else begin : g_src_stage
				assign stg_in[k] = ax_s[k-1];
			end

			// each axis in turn: invert low bits of x, or exchange them with x
			always_comb begin
				logic [BITS-1:0] sw;
				sw         = '0;
				stg_nxt[k] = stg_in[k];
				for (int i = 0; i < DIMS; i++) begin
					if (stg_nxt[k][i][P]) begin
						stg_nxt[k][0] = stg_nxt[k][0] ^ LOW;
					end else begin
						sw            = (stg_nxt[k][0] ^ stg_nxt[k][i]) & LOW;
						stg_nxt[k][0] = stg_nxt[k][0] ^ sw;
						stg_nxt[k][i] = stg_nxt[k][i] ^ sw;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (ready[k] && prev_valid[k-1]) begin
					ax_s[k] <= stg_nxt[k];
				end
			end
		end
	endgenerate

	// gray encode across the axes, apply the correction mask, interleave
	always_comb begin
		axes_t           g;
		logic [BITS-1:0] corr;
		g[0] = ax_s[BITS-1][0];
		for (int i = 1; i < DIMS; i++) begin
			g[i] = ax_s[BITS-1][i] ^ g[i-1];
		end
		// bit j of the mask is the parity of the last axis above bit j
		for (int j = 0; j < BITS; j++) begin
			corr[j] = ^(g[DIMS-1] >> (j + 1));
		end
		for (int i = 0; i < DIMS; i++) begin
			g[i] = g[i] ^ corr;
		end
		for (int p = 0; p < BITS; p++) begin
			for (int i = 0; i < DIMS; i++) begin
				dist_nxt[p*DIMS + (DIMS-1-i)] = g[i][p];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready[BITS] && prev_valid[BITS-1]) begin
			dist_s <= dist_nxt;
		end
	end

	assign curve_distance = dist_s;
	assign dist_valid     = valid_s[BITS];

endmodule

/* rtl/hi3d_checker.sv */
`timescale 1ns / 1ps

`include "hilbert_index_3d_assert.svh"

module hi3d_checker #(
	parameter int BITS = 10,
	parameter int DIMS = 3
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 point_valid,
	input logic                 point_stall,
	input logic [BITS*DIMS-1:0] curve_distance,
	input logic                 dist_valid,
	input logic                 dist_stall
);

	// enough for one point in every stage plus one
	localparam int CW = $clog2(BITS + 2);

	logic          in_xfer;
	logic          out_xfer;
	logic [CW-1:0] inflight_q;

	assign in_xfer  = point_valid && !point_stall;
	assign out_xfer = dist_valid && !dist_stall;

	// points taken in and not yet handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CW'(in_xfer) - CW'(out_xfer);
		end
	end

	`HI3D_ASSERT_NEXT(a_dist_hold, dist_valid && dist_stall, dist_valid && $stable(curve_distance), "stalled result changed or dropped")
	`HI3D_ASSERT_NOW(a_no_phantom, dist_valid, inflight_q != '0, "result with no point in flight")
	`HI3D_ASSERT_NOW(a_depth, 1'b1, inflight_q <= CW'(BITS), "more points in flight than stages")
	`HI3D_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n), !dist_valid, "result valid straight after reset")

endmodule

bind hilbert_index_3d hi3d_checker #(.BITS(BITS), .DIMS(DIMS)) u_hi3d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.point_valid    (point_valid),
	.point_stall    (point_stall),
	.curve_distance (curve_distance),
	.dist_valid     (dist_valid),
	.dist_stall     (dist_stall)
);
